FILE: rtl/core/hbr_pkg.sv
// Shared types and constants for the HTTP byte-range parser.
package hbr_pkg;

    localparam int FIELD_W    = 64;
    localparam int PREFIX_LEN = 6;

    localparam logic [7:0] PREFIX_TEXT [0:PREFIX_LEN-1] =
        '{8'h62, 8'h79, 8'h74, 8'h65, 8'h73, 8'h3D};  // "bytes="

    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [1:0] STATUS_NONE    = 2'd0;
    localparam logic [1:0] STATUS_VALID   = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    typedef logic [FIELD_W-1:0] hbr_off_t;

    // Form of a finished header, handed from the front end to the back end
    typedef enum logic [1:0] {
        KIND_INVALID = 2'd0,
        KIND_SUFFIX  = 2'd1,
        KIND_OPEN    = 2'd2,
        KIND_CLOSED  = 2'd3
    } hbr_kind_t;

    typedef struct packed {
        logic [7:0] header_char;
        logic       is_final;
    } hbr_in_t;

    typedef struct packed {
        logic [1:0] range_status;
        hbr_off_t   first_offset;
        hbr_off_t   range_end;
    } hbr_out_t;

endpackage

FILE: rtl/core/http_byte_range_parser.sv
// Top level of the HTTP byte-range parser: size register, front end, queue, back end.
//
//  Channel     | Dir | Handshake             | Beat
//  ------------+-----+-----------------------+---------------------------------------
//  char        | in  | char_valid/char_stall | header_char, is_final
//  range       | out | range_valid/range_stall | range_status, first_offset, range_end
//  cfg         | in  | cfg_wr_en             | cfg_wr_data -> resource_size
//
//  One header character is taken per cycle while char_stall is low; the decimal
//  times-ten accumulate in the front end is the only per-character work and is
//  combinational. A result passes from its final character through the queue
//  and then the back end's range check and output register.
//  rst_n clears the parse state, the queue, the output valid and the size register.
//  char_stall rises only when the two-entry queue is full, so a stalled result
//  side stops input after at most three finished headers are held.
module http_byte_range_parser #(
    parameter int OFFSET_WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_stall,
    input  hbr_pkg::hbr_in_t   char_beat,
    output logic               range_valid,
    input  logic               range_stall,
    output hbr_pkg::hbr_out_t  range_beat,
    input  logic               cfg_wr_en,
    input  logic [63:0]        cfg_wr_data
);

    localparam int JOB_W = 2 + 2 * OFFSET_WIDTH;

    logic [OFFSET_WIDTH-1:0] size_reg;

    logic                    char_accept;
    logic                    job_push;
    hbr_pkg::hbr_kind_t      push_kind;
    logic [OFFSET_WIDTH-1:0] push_first;
    logic [OFFSET_WIDTH-1:0] push_second;
    logic [JOB_W-1:0]        push_data;
    logic [JOB_W-1:0]        pop_data;
    logic                    job_pop;
    logic                    queue_full;
    logic                    queue_not_empty;
    hbr_pkg::hbr_kind_t      pop_kind;

    // hold input off only while the queue has no free slot
    assign char_stall  = queue_full;
    assign char_accept = char_valid && !queue_full;

    // size is masked to the offset width at write time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= '0;
        else if (cfg_wr_en)
            size_reg <= cfg_wr_data[OFFSET_WIDTH-1:0];
    end

    hbr_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_accept (char_accept),
        .header_char (char_beat.header_char),
        .is_final    (char_beat.is_final),
        .job_push    (job_push),
        .job_kind    (push_kind),
        .job_first   (push_first),
        .job_second  (push_second)
    );

    assign push_data = {push_kind, push_first, push_second};

    hbr_queue #(
        .DATA_WIDTH (JOB_W),
        .DEPTH      (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (push_data),
        .pop       (job_pop),
        .pop_data  (pop_data),
        .full      (queue_full),
        .not_empty (queue_not_empty)
    );

    assign pop_kind = hbr_pkg::hbr_kind_t'(pop_data[JOB_W-1:JOB_W-2]);

    hbr_back #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (queue_not_empty),
        .job_kind    (pop_kind),
        .job_first   (pop_data[2*OFFSET_WIDTH-1:OFFSET_WIDTH]),
        .job_second  (pop_data[OFFSET_WIDTH-1:0]),
        .size        (size_reg),
        .job_pop     (job_pop),
        .range_stall (range_stall),
        .range_valid (range_valid),
        .range_beat  (range_beat)
    );

    a_size_masked: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (size_reg == $past(cfg_wr_data[OFFSET_WIDTH-1:0])))
        else $error("resource size not taken from write data");

endmodule

FILE: rtl/core/hbr_front.sv
// Front end: prefix match, parse phase and saturating decimal accumulators.
module hbr_front #(
    parameter int OFFSET_WIDTH = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    char_accept,
    input  logic [7:0]              header_char,
    input  logic                    is_final,
    output logic                    job_push,
    output hbr_pkg::hbr_kind_t      job_kind,
    output logic [OFFSET_WIDTH-1:0] job_first,
    output logic [OFFSET_WIDTH-1:0] job_second
);

    typedef enum logic [3:0] {
        PH_PRE0    = 4'd0,
        PH_PRE1    = 4'd1,
        PH_PRE2    = 4'd2,
        PH_PRE3    = 4'd3,
        PH_PRE4    = 4'd4,
        PH_PRE5    = 4'd5,
        PH_START   = 4'd6,
        PH_SUFFIX  = 4'd7,
        PH_SUFEND  = 4'd8,
        PH_FIRST   = 4'd9,
        PH_OPENEND = 4'd10,
        PH_DASH    = 4'd11,
        PH_LAST    = 4'd12,
        PH_DEAD    = 4'd13
    } phase_t;

    localparam logic [OFFSET_WIDTH-1:0] ACC_ZERO = '0;
    localparam logic [OFFSET_WIDTH-1:0] ACC_TOP  = '1;

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [OFFSET_WIDTH-1:0] first_reg;
    logic [OFFSET_WIDTH-1:0] first_next;
    logic [OFFSET_WIDTH-1:0] second_reg;
    logic [OFFSET_WIDTH-1:0] second_next;

    logic                    is_digit;
    logic [OFFSET_WIDTH-1:0] acc_base;
    logic [OFFSET_WIDTH+3:0] acc_wide;
    logic [OFFSET_WIDTH-1:0] acc_sum;

    assign is_digit = (header_char >= hbr_pkg::CHAR_ZERO) &&
                      (header_char <= hbr_pkg::CHAR_NINE);

    // times ten plus digit; saturate when the result leaves the offset width
    always_comb
    begin
        if (phase_reg == PH_FIRST)
            acc_base = first_reg;
        else if ((phase_reg == PH_SUFFIX) || (phase_reg == PH_LAST))
            acc_base = second_reg;
        else
            acc_base = ACC_ZERO;
        acc_wide = ({4'd0, acc_base} << 3) + ({4'd0, acc_base} << 1)
                 + {{OFFSET_WIDTH{1'b0}}, header_char[3:0]};
        acc_sum  = (acc_wide[OFFSET_WIDTH+3:OFFSET_WIDTH] != 4'd0) ?
                   ACC_TOP : acc_wide[OFFSET_WIDTH-1:0];
    end

    always_comb
    begin
        phase_next  = phase_reg;
        first_next  = first_reg;
        second_next = second_reg;
        if (phase_reg < PH_START)
        begin
            if (header_char == hbr_pkg::PREFIX_TEXT[phase_reg[2:0]])
                phase_next = phase_t'(phase_reg + 4'd1);
            else
                phase_next = PH_DEAD;
        end
        else
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (header_char == hbr_pkg::CHAR_DASH)
                        phase_next = PH_SUFFIX;
                    else if (is_digit)
                    begin
                        first_next = acc_sum;
                        phase_next = PH_FIRST;
                    end
                    else
                        phase_next = PH_OPENEND;
                end
                PH_SUFFIX:
                begin
                    if (is_digit)
                        second_next = acc_sum;
                    else
                        phase_next = PH_SUFEND;
                end
                PH_FIRST:
                begin
                    if (is_digit)
                        first_next = acc_sum;
                    else if (header_char == hbr_pkg::CHAR_DASH)
                        phase_next = PH_DASH;
                    else
                        phase_next = PH_OPENEND;
                end
                PH_DASH, PH_LAST:
                begin
                    if (is_digit)
                    begin
                        second_next = acc_sum;
                        phase_next  = PH_LAST;
                    end
                    else
                        phase_next = PH_DEAD;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // classify the header as it stands after the final character
    always_comb
    begin
        if ((phase_next < PH_START) || (phase_next == PH_DEAD))
            job_kind = hbr_pkg::KIND_INVALID;
        else if ((phase_next == PH_SUFFIX) || (phase_next == PH_SUFEND))
            job_kind = hbr_pkg::KIND_SUFFIX;
        else if (phase_next == PH_LAST)
            job_kind = hbr_pkg::KIND_CLOSED;
        else
            job_kind = hbr_pkg::KIND_OPEN;
    end

    assign job_push   = char_accept && is_final;
    assign job_first  = first_next;
    assign job_second = second_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PRE0;
            first_reg  <= ACC_ZERO;
            second_reg <= ACC_ZERO;
        end
        else if (char_accept)
        begin
            if (is_final)
            begin
                phase_reg  <= PH_PRE0;
                first_reg  <= ACC_ZERO;
                second_reg <= ACC_ZERO;
            end
            else
            begin
                phase_reg  <= phase_next;
                first_reg  <= first_next;
                second_reg <= second_next;
            end
        end
    end

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (char_accept && is_final) |=> (phase_reg == PH_PRE0 && first_reg == ACC_ZERO))
        else $error("parse state not cleared after final character");

    a_dead_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DEAD && !(char_accept && is_final)) |=> (phase_reg == PH_DEAD))
        else $error("invalid header left dead phase before its end");

endmodule

FILE: rtl/core/hbr_queue.sv
// Short queue of classified headers between front end and back end.
module hbr_queue #(
    parameter int DATA_WIDTH = 130,
    parameter int DEPTH      = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [DATA_WIDTH-1:0] push_data,
    input  logic                  pop,
    output logic [DATA_WIDTH-1:0] pop_data,
    output logic                  full,
    output logic                  not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_WIDTH-1:0] slot_reg [0:DEPTH-1];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("push into full queue");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

endmodule

FILE: rtl/core/hbr_back.sv
// Back end: range checks against the resource size and the output register.
module hbr_back #(
    parameter int OFFSET_WIDTH = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    job_valid,
    input  hbr_pkg::hbr_kind_t      job_kind,
    input  logic [OFFSET_WIDTH-1:0] job_first,
    input  logic [OFFSET_WIDTH-1:0] job_second,
    input  logic [OFFSET_WIDTH-1:0] size,
    output logic                    job_pop,
    input  logic                    range_stall,
    output logic                    range_valid,
    output hbr_pkg::hbr_out_t       range_beat
);

    localparam logic [OFFSET_WIDTH-1:0] OFF_ZERO = '0;
    localparam logic [OFFSET_WIDTH-1:0] OFF_ONE  = OFFSET_WIDTH'(1);

    logic                    valid_reg;
    hbr_pkg::hbr_out_t       beat_reg;
    logic [1:0]              status_next;
    logic [OFFSET_WIDTH-1:0] skip_next;
    logic [OFFSET_WIDTH-1:0] end_next;

    logic second_ge_size;
    logic first_ge_size;
    logic second_lt_first;

    assign second_ge_size  = (job_second >= size);
    assign first_ge_size   = (job_first >= size);
    assign second_lt_first = (job_second < job_first);

    always_comb
    begin
        status_next = hbr_pkg::STATUS_INVALID;
        skip_next   = OFF_ZERO;
        end_next    = size;
        unique case (job_kind)
            hbr_pkg::KIND_SUFFIX:
            begin
                if (second_ge_size)
                    status_next = hbr_pkg::STATUS_NONE;
                else
                begin
                    status_next = hbr_pkg::STATUS_VALID;
                    skip_next   = size - job_second;
                end
            end
            hbr_pkg::KIND_OPEN:
            begin
                if (!first_ge_size)
                begin
                    status_next = hbr_pkg::STATUS_VALID;
                    skip_next   = job_first;
                end
            end
            hbr_pkg::KIND_CLOSED:
            begin
                if (!first_ge_size && !second_lt_first && !second_ge_size)
                begin
                    status_next = hbr_pkg::STATUS_VALID;
                    skip_next   = job_first;
                    end_next    = job_second + OFF_ONE;
                end
            end
            hbr_pkg::KIND_INVALID:
            begin
                status_next = hbr_pkg::STATUS_INVALID;
            end
        endcase
    end

    // load when the output register is empty or its beat leaves this cycle
    assign job_pop     = job_valid && (!valid_reg || !range_stall);
    assign range_valid = valid_reg;
    assign range_beat  = beat_reg;

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            beat_reg.range_status <= status_next;
            beat_reg.first_offset <= hbr_pkg::hbr_off_t'(skip_next);
            beat_reg.range_end    <= hbr_pkg::hbr_off_t'(end_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (job_pop)
            valid_reg <= 1'b1;
        else if (!range_stall)
            valid_reg <= 1'b0;
    end

    a_valid_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && beat_reg.range_status == hbr_pkg::STATUS_VALID)
        |-> (beat_reg.first_offset <= beat_reg.range_end))
        else $error("valid range starts past its end");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the HTTP byte-range parser.
`timescale 1ns / 1ps

module testbench;

    localparam int                OFFSET_W      = 64;
    localparam hbr_pkg::hbr_off_t VALUE_MASK    = {64{1'b1}} >> (64 - OFFSET_W);
    localparam int                RANDOM_CHARS  = 1450;
    localparam int                RANDOM_PHASES = 10;
    localparam int                IDLE_TAIL     = 10;    // queue and output register plus margin
    localparam int                IDLE_LIMIT    = 1000;  // cycles without any beat moving
    localparam int                MAX_REPORTS   = 10;

    // Parse phases of the predictor; the prefix position is kept apart
    typedef enum logic [3:0] {
        PS_PREFIX,
        PS_START,
        PS_SUFFIX,
        PS_SUFEND,
        PS_FIRST,
        PS_OPENEND,
        PS_DASH,
        PS_LAST,
        PS_DEAD
    } parse_state_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               char_valid  = 1'b0;
    logic               char_stall;
    hbr_pkg::hbr_in_t   char_beat   = '0;
    logic               range_valid;
    logic               range_stall = 1'b0;
    hbr_pkg::hbr_out_t  range_beat;
    logic               cfg_wr_en   = 1'b0;
    logic [63:0]        cfg_wr_data = '0;

    http_byte_range_parser #(
        .OFFSET_WIDTH (OFFSET_W)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_beat   (char_beat),
        .range_valid (range_valid),
        .range_stall (range_stall),
        .range_beat  (range_beat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the size register and the parse
    // ------------------------------------------------------------------
    hbr_pkg::hbr_off_t size_reg = '0;
    parse_state_t      p_state  = PS_PREFIX;
    int                p_pos    = 0;
    hbr_pkg::hbr_off_t p_first  = '0;
    hbr_pkg::hbr_off_t p_second = '0;

    hbr_pkg::hbr_in_t  pending_q[$];      // characters waiting for the driver
    hbr_pkg::hbr_out_t range_expect_q[$]; // predicted results, oldest first
    logic [7:0]        hdr_buf[$];        // header under construction
    int                chars_queued = 0;
    int                mismatches   = 0;
    int                idle_cycles  = 0;
    int                burst_left   = 0;
    int                gap_left     = 0;
    int                stall_mode   = 0;
    int                stall_seg    = 0;
    int                stall_run    = 0;

    function automatic logic is_digit(logic [7:0] c);
        return c >= hbr_pkg::CHAR_ZERO && c <= hbr_pkg::CHAR_NINE;
    endfunction

    // Times-ten accumulate; saturate to all ones on overflow
    function automatic hbr_pkg::hbr_off_t acc_digit(hbr_pkg::hbr_off_t acc, logic [7:0] c);
        hbr_pkg::hbr_off_t d;
        d = hbr_pkg::hbr_off_t'(c) - hbr_pkg::hbr_off_t'(hbr_pkg::CHAR_ZERO);
        if (acc > (VALUE_MASK - d) / 10)
            return VALUE_MASK;
        return acc * 10 + d;
    endfunction

    // Advance the parse by one accepted character; on the final one, queue
    // the expected range and clear the parse.
    task automatic predict_char(input hbr_pkg::hbr_in_t b);
        logic [7:0]        c;
        hbr_pkg::hbr_out_t res;
        c = b.header_char;
        case (p_state)
            PS_PREFIX:
            begin
                if (c != hbr_pkg::PREFIX_TEXT[p_pos])
                    p_state = PS_DEAD;
                else if (p_pos == hbr_pkg::PREFIX_LEN - 1)
                    p_state = PS_START;
                else
                    p_pos++;
            end
            PS_START:
            begin
                if (c == hbr_pkg::CHAR_DASH)
                    p_state = PS_SUFFIX;
                else if (is_digit(c))
                begin
                    p_first = acc_digit('0, c);
                    p_state = PS_FIRST;
                end
                else
                    p_state = PS_OPENEND;
            end
            PS_SUFFIX:
            begin
                if (is_digit(c))
                    p_second = acc_digit(p_second, c);
                else
                    p_state = PS_SUFEND;
            end
            PS_FIRST:
            begin
                if (is_digit(c))
                    p_first = acc_digit(p_first, c);
                else if (c == hbr_pkg::CHAR_DASH)
                    p_state = PS_DASH;
                else
                    p_state = PS_OPENEND;
            end
            PS_DASH:
            begin
                if (is_digit(c))
                begin
                    p_second = acc_digit('0, c);
                    p_state  = PS_LAST;
                end
                else
                    p_state = PS_DEAD;
            end
            PS_LAST:
            begin
                if (!is_digit(c))
                    p_state = PS_DEAD;
                else
                    p_second = acc_digit(p_second, c);
            end
            default: ;
        endcase

        if (b.is_final)
        begin
            res.range_status = hbr_pkg::STATUS_INVALID;
            res.first_offset = '0;
            res.range_end    = size_reg;
            case (p_state)
                PS_PREFIX, PS_DEAD: ;
                PS_SUFFIX, PS_SUFEND:
                begin
                    // suffix at least as long as the resource: serve it whole
                    if (p_second >= size_reg)
                        res.range_status = hbr_pkg::STATUS_NONE;
                    else
                    begin
                        res.range_status = hbr_pkg::STATUS_VALID;
                        res.first_offset = size_reg - p_second;
                    end
                end
                default:
                begin
                    if (p_first >= size_reg)
                        res.range_status = hbr_pkg::STATUS_INVALID;
                    else if (p_state == PS_LAST)
                    begin
                        if (p_second >= p_first && p_second < size_reg)
                        begin
                            res.range_status = hbr_pkg::STATUS_VALID;
                            res.first_offset = p_first;
                            res.range_end    = p_second + 1;
                        end
                    end
                    else
                    begin
                        res.range_status = hbr_pkg::STATUS_VALID;
                        res.first_offset = p_first;
                    end
                end
            endcase
            range_expect_q.push_back(res);
            p_state  = PS_PREFIX;
            p_pos    = 0;
            p_first  = '0;
            p_second = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Header construction
    // ------------------------------------------------------------------
    function automatic hbr_pkg::hbr_off_t rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(32, 126));
    endfunction

    task automatic put_char(input logic [7:0] c);
        hdr_buf.push_back(c);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            hdr_buf.push_back(s[i]);
    endtask

    // Append v in decimal, now and then with leading zeros
    task automatic put_number(input hbr_pkg::hbr_off_t v);
        logic [7:0]        digs[$];
        hbr_pkg::hbr_off_t t;
        t = v;
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) hdr_buf.push_back(hbr_pkg::CHAR_ZERO);
        if (t == 0)
            digs.push_front(hbr_pkg::CHAR_ZERO);
        while (t != 0)
        begin
            digs.push_front(hbr_pkg::CHAR_ZERO + 8'(t % 10));
            t = t / 10;
        end
        foreach (digs[i])
            hdr_buf.push_back(digs[i]);
    endtask

    // Long random digit strings drive the accumulators into saturation
    task automatic put_digits(input int n);
        repeat (n) hdr_buf.push_back(hbr_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic put_garbage(input int n);
        repeat (n) hdr_buf.push_back(rand_byte());
    endtask

    // Move the built header to the driver queue; mark its last character
    task automatic flush_header();
        hbr_pkg::hbr_in_t b;
        foreach (hdr_buf[i])
        begin
            b.header_char = hdr_buf[i];
            b.is_final    = (i == hdr_buf.size() - 1);
            pending_q.push_back(b);
        end
        chars_queued += hdr_buf.size();
        hdr_buf.delete();
    endtask

    task automatic send_text(input string s);
        put_text(s);
        flush_header();
    endtask

    // Offsets clustered around the edges of the resource
    function automatic hbr_pkg::hbr_off_t pick_value(hbr_pkg::hbr_off_t lim);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return (lim == 0) ? '0 : lim - 1;
            2: return lim;
            3: return lim + 1;
            4: return (lim == 0) ? '0 : rand64() % lim;
            5: return rand64();
            6: return hbr_pkg::hbr_off_t'($urandom_range(0, 99));
            default: return VALUE_MASK;
        endcase
    endfunction

    function automatic hbr_pkg::hbr_off_t pick_last(hbr_pkg::hbr_off_t first,
                                                    hbr_pkg::hbr_off_t lim);
        case ($urandom_range(0, 6))
            0: return first;
            1: return first + hbr_pkg::hbr_off_t'($urandom_range(1, 50));
            2: return (lim == 0) ? '0 : lim - 1;
            3: return lim;
            4: return first - 1;
            5: return (first < lim) ? first + rand64() % (lim - first) : first;
            default: return pick_value(lim);
        endcase
    endfunction

    function automatic hbr_pkg::hbr_off_t pick_size();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return hbr_pkg::hbr_off_t'(1);
            2: return hbr_pkg::hbr_off_t'($urandom_range(2, 100));
            3: return hbr_pkg::hbr_off_t'($urandom_range(100, 100000));
            4: return rand64();
            5: return VALUE_MASK;
            default: return VALUE_MASK - hbr_pkg::hbr_off_t'($urandom_range(1, 1000));
        endcase
    endfunction

    // One random header; mostly well-formed, some broken, some noise
    task automatic gen_header();
        int                kind;
        int                cut;
        hbr_pkg::hbr_off_t first;
        string             seps;
        seps  = "/x,;";
        kind  = $urandom_range(0, 19);
        first = pick_value(size_reg);
        if (kind < 15)
            put_text("bytes=");
        if (kind <= 2)
        begin
            put_char(hbr_pkg::CHAR_DASH);
            put_number(pick_value(size_reg));
            if ($urandom_range(0, 3) == 0)
                put_garbage($urandom_range(1, 3));
        end
        else if (kind <= 4)
        begin
            put_number(first);
            put_char(hbr_pkg::CHAR_DASH);
        end
        else if (kind <= 6)
            put_number(first);
        else if (kind <= 8)
        begin
            put_number(first);
            put_char(seps[$urandom_range(0, 3)]);
            put_garbage($urandom_range(0, 4));
        end
        else if (kind <= 14)
        begin
            put_number(first);
            put_char(hbr_pkg::CHAR_DASH);
            put_number(pick_last(first, size_reg));
            if (kind >= 13)
                put_garbage($urandom_range(1, 2));
        end
        else if (kind <= 16)
        begin
            // broken or truncated prefix
            cut = $urandom_range(0, hbr_pkg::PREFIX_LEN - 1);
            for (int i = 0; i < cut; i++)
                put_char(hbr_pkg::PREFIX_TEXT[i]);
            if (cut == 0 || $urandom_range(0, 1) == 0)
            begin
                put_char(rand_byte());
                put_garbage($urandom_range(0, 6));
            end
        end
        else if (kind == 17)
            put_garbage($urandom_range(1, 12));
        else
        begin
            put_text("bytes=");
            case ($urandom_range(0, 4))
                0: ;
                1: put_char(hbr_pkg::CHAR_DASH);
                2:
                begin
                    put_number(first);
                    put_text("--");
                end
                3:
                begin
                    put_digits($urandom_range(18, 25));
                    if ($urandom_range(0, 1) == 0)
                    begin
                        put_char(hbr_pkg::CHAR_DASH);
                        put_digits($urandom_range(1, 25));
                    end
                end
                default:
                begin
                    put_number(first);
                    put_char(hbr_pkg::CHAR_DASH);
                    put_char(rand_byte());
                end
            endcase
        end
        flush_header();
    endtask

    // Write the size register; only called with nothing in flight
    task automatic write_size(input hbr_pkg::hbr_off_t v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        size_reg = v & VALUE_MASK;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Hold until every character is taken and every range has come back
    task automatic drain();
        @(negedge clk);
        while (pending_q.size() != 0 || char_valid || range_expect_q.size() != 0)
            @(negedge clk);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        int target;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed headers against a mid-sized resource
        write_size(64'd1000);
        send_text("bytes=0-499");
        send_text("bytes=-100");
        send_text("bytes=-1000");
        send_text("bytes=-");
        send_text("bytes=-5abc");
        send_text("bytes=500-");
        send_text("bytes=500");
        send_text("bytes=5x9");
        send_text("bytes=999-999");
        send_text("bytes=1000-");
        send_text("bytes=10-5");
        send_text("bytes=10-1000");
        send_text("bytes=1-2x");
        send_text("bytes=5--");
        send_text("bytes=");
        send_text("byte");
        send_text("bytez=1-2");
        send_text("bytes=99999999999999999999-");
        put_text("bytes=1");
        put_char(8'h00);
        flush_header();
        put_char(8'hFF);
        flush_header();
        drain();

        // empty resource: nothing can be a valid start
        write_size('0);
        send_text("bytes=-0");
        send_text("bytes=0-0");
        send_text("bytes=0");
        drain();

        // largest resource: saturation lands exactly on the size
        write_size(VALUE_MASK);
        send_text("bytes=18446744073709551614-18446744073709551614");
        send_text("bytes=-18446744073709551615");
        send_text("bytes=18446744073709551615-");
        send_text("bytes=99999999999999999999999");
        drain();

        // random phases, each with its own resource size
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_size(pick_size());
            target = chars_queued + RANDOM_CHARS / RANDOM_PHASES;
            while (chars_queued < target)
                gen_header();
            drain();
        end

        if (mismatches == 0)
            $display("[http_byte_range_parser] OK");
        else
            $display("[http_byte_range_parser] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Character driver: bursts of random length with random gaps. Predict
    // each beat as it is taken; hold the payload while stalled.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : p_drive
        logic take;
        take = char_valid && !char_stall;
        if (take)
            predict_char(char_beat);
        if (!char_valid || take)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                char_valid <= 1'b0;
            end
            else if (pending_q.size() != 0)
            begin
                char_beat  <= pending_q.pop_front();
                char_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    // a third of the bursts run straight into the next one
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
                end
            end
            else
                char_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result stall pattern: segments of no stall, coin-flip stall, and
    // long stall runs.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : p_stall
        if (stall_seg == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_seg  = $urandom_range(20, 200);
            stall_run  = 0;
        end
        else
            stall_seg--;
        case (stall_mode)
            0: range_stall <= 1'b0;
            1: range_stall <= 1'($urandom_range(0, 1));
            default:
            begin
                if (stall_run > 0)
                begin
                    stall_run--;
                    range_stall <= 1'b1;
                end
                else
                begin
                    range_stall <= 1'b0;
                    if ($urandom_range(0, 7) == 0)
                        stall_run = $urandom_range(1, 25);
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each taken beat with the oldest prediction
    // ------------------------------------------------------------------
    function automatic void check_field(string fname, hbr_pkg::hbr_off_t exp_v,
                                        hbr_pkg::hbr_off_t act_v);
        if (exp_v !== act_v)
        begin
            if (mismatches < MAX_REPORTS)
                $display("mismatch %s: expected %0d, got %0d", fname, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : p_monitor
        hbr_pkg::hbr_out_t want;
        if (rst_n && range_valid && !range_stall)
        begin
            if (range_expect_q.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected range beat: status %0d", range_beat.range_status);
                mismatches++;
            end
            else
            begin
                want = range_expect_q.pop_front();
                check_field("range_status", hbr_pkg::hbr_off_t'(want.range_status),
                            hbr_pkg::hbr_off_t'(range_beat.range_status));
                check_field("first_offset", want.first_offset, range_beat.first_offset);
                check_field("range_end", want.range_end, range_beat.range_end);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: drop the run when no beat moves for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((char_valid && !char_stall) || (range_valid && !range_stall))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("[http_byte_range_parser] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
